// ===== rtl/naive_exact_pattern_matcher_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the exact pattern matcher
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NAIVE_EXACT_PATTERN_MATCHER_TOP_DEFINES_SVH
`define NAIVE_EXACT_PATTERN_MATCHER_TOP_DEFINES_SVH

// Checked only while reset is released.
`define NEPM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("nepm assertion failed");

// Checked at every edge, reset included.
`define NEPM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("nepm assertion failed");

`endif

// ===== rtl/nepm_pkg.sv =====
// ----------------------------------------------------------------------------
// nepm_pkg
// Types and constants shared by the exact pattern matcher modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nepm_pkg;

    localparam int C_MAX_PATTERN   = 128;
    localparam int C_POSITION_BITS = 32;

    // Item kinds after classification
    typedef logic t_kind;
    localparam t_kind K_PATTERN = 1'b0;
    localparam t_kind K_TEXT    = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] symbol;
        logic       first;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        is_match;
        logic [31:0] match_start;
        logic        done_res;
    } t_out_item;

    // Classified transaction between front and back
    typedef struct packed {
        t_kind      kind;
        logic       first;
        logic       last;
        logic [7:0] symbol;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/nepm_front.sv =====
// ----------------------------------------------------------------------------
// nepm_front
// Accepts input transactions, classifies them and queues them (two entries)
// for the match engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nepm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  nepm_pkg::t_in_item i_item,
    output logic              o_cmd_vld,
    output nepm_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import nepm_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       cls;
    logic       do_push;
    logic       do_pop;

    always_comb begin
        cls.kind   = i_item.command ? K_TEXT : K_PATTERN;
        cls.first  = i_item.first;
        // last only matters on text
        cls.last   = i_item.command & i_item.last;
        cls.symbol = i_item.symbol;
    end

    assign full      = (r_cnt == 2'd2);
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rd];
    assign do_push   = push & ~full;
    assign do_pop    = i_cmd_pop & o_cmd_vld;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push & ~do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop & ~do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nepm_back.sv =====
// ----------------------------------------------------------------------------
// nepm_back
// Match engine: stores pattern symbols, keeps the circular text window and,
// per text symbol once it holds the pattern length, walks one pair per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nepm_back #(
    parameter int MAX_PATTERN   = nepm_pkg::C_MAX_PATTERN,
    parameter int POSITION_BITS = nepm_pkg::C_POSITION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_vld,
    input  nepm_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    output logic               o_res_vld,
    output nepm_pkg::t_out_item o_res,
    input  logic               i_res_full
);
    import nepm_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PATTERN - 1);
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PATTERN);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic [LEN_W-1:0]         r_len;
    logic [LEN_W-1:0]         r_fill;
    logic [IDX_W-1:0]         r_head;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_start;
    logic [LEN_W-1:0]         r_cnt;
    logic [IDX_W-1:0]         r_rd_ptr;
    logic                     r_chk_vld;
    logic                     r_miss;
    logic                     r_last;
    logic                     r_hit;

    logic [7:0] pat_mem [MAX_PATTERN];
    logic [7:0] win_mem [MAX_PATTERN];
    logic [7:0] r_pat_q;
    logic [7:0] r_win_q;

    logic                     take;
    logic                     is_text;
    logic [IDX_W-1:0]         head_eff;
    logic [LEN_W-1:0]         fill_eff;
    logic [POSITION_BITS-1:0] pos_eff;
    logic [IDX_W-1:0]         head_new;
    logic [LEN_W-1:0]         fill_new;
    logic                     can_hit;
    logic [IDX_W-1:0]         back_i;
    logic [IDX_W-1:0]         rd_first;
    logic                     pat_we;
    logic [IDX_W-1:0]         pat_waddr;
    logic                     issue;
    logic                     cmp_done;

    assign take      = (r_state == S_IDLE) && i_cmd_vld;
    assign o_cmd_pop = take;
    assign is_text   = (i_cmd.kind == K_TEXT);

    // Window bookkeeping for the incoming text symbol; first restarts the text
    always_comb begin
        head_eff = i_cmd.first ? '0 : r_head;
        fill_eff = i_cmd.first ? '0 : r_fill;
        pos_eff  = i_cmd.first ? '0 : r_pos;
        head_new = (head_eff == LAST_IDX) ? '0 : head_eff + IDX_W'(1);
        fill_new = (fill_eff == MAX_LEN) ? fill_eff : fill_eff + LEN_W'(1);
        can_hit  = (r_len != '0) && (fill_new >= r_len);
        back_i   = IDX_W'(r_len - LEN_W'(1));
        if (head_new >= back_i) begin
            rd_first = head_new - back_i;
        end else begin
            rd_first = IDX_W'({1'b0, head_new} + (IDX_W+1)'(MAX_PATTERN) - {1'b0, back_i});
        end
    end

    assign pat_we    = take && !is_text && (i_cmd.first || (r_len != MAX_LEN));
    assign pat_waddr = i_cmd.first ? '0 : r_len[IDX_W-1:0];

    assign issue    = (r_cnt != r_len);
    assign cmp_done = !issue && !r_chk_vld;

    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            pat_mem[pat_waddr] <= i_cmd.symbol;
        end
        r_pat_q <= pat_mem[r_cnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (take && is_text) begin
            win_mem[head_new] <= i_cmd.symbol;
        end
        r_win_q <= win_mem[r_rd_ptr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take && is_text) begin
                    if (can_hit) begin
                        n_state = S_CMP;
                    end else if (i_cmd.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CMP: begin
                if (cmp_done) begin
                    n_state = (!r_miss || r_last) ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_fill    <= '0;
            r_head    <= '0;
            r_pos     <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= (r_state == S_CMP) && issue;
            if (pat_we) begin
                r_len <= i_cmd.first ? LEN_W'(1) : r_len + LEN_W'(1);
            end
            if (take && is_text) begin
                r_head <= head_new;
                r_fill <= fill_new;
                r_pos  <= pos_eff + POSITION_BITS'(1);
            end
            // end of text: drop the window state
            if ((r_state == S_EMIT) && !i_res_full && r_last) begin
                r_head <= '0;
                r_fill <= '0;
                r_pos  <= '0;
            end
        end
    end

    // Compare walk and result payload
    always_ff @(posedge i_clk) begin
        if (take && is_text) begin
            r_last   <= i_cmd.last;
            r_hit    <= 1'b0;
            r_cnt    <= '0;
            r_rd_ptr <= rd_first;
            r_miss   <= 1'b0;
            r_start  <= pos_eff - POSITION_BITS'(r_len) + POSITION_BITS'(1);
        end else if (r_state == S_CMP) begin
            if (issue) begin
                r_cnt    <= r_cnt + LEN_W'(1);
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + IDX_W'(1);
            end
            if (r_chk_vld && (r_pat_q != r_win_q)) begin
                r_miss <= 1'b1;
            end
            if (cmp_done) begin
                r_hit <= !r_miss;
            end
        end
    end

    assign o_res_vld = (r_state == S_EMIT);

    always_comb begin
        o_res.is_match    = r_hit;
        o_res.match_start = r_hit ? 32'(r_start) : 32'd0;
        o_res.done_res    = r_last;
    end

endmodule

`default_nettype wire

// ===== rtl/nepm_outq.sv =====
// ----------------------------------------------------------------------------
// nepm_outq
// Two-entry result queue; decouples the match engine from the consumer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nepm_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  nepm_pkg::t_out_item i_res,
    output logic                o_full,
    output logic                empty,
    input  logic                pop,
    output nepm_pkg::t_out_item o_result
);
    import nepm_pkg::*;

    t_out_item  r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       do_wr;
    logic       do_rd;

    assign o_full   = (r_cnt == 2'd2);
    assign empty    = (r_cnt == 2'd0);
    assign o_result = r_q[r_rd];
    assign do_wr    = i_wr & ~o_full;
    assign do_rd    = pop & ~empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_wr & ~do_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_rd & ~do_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_q[r_wr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (do_wr) begin
                r_wr <= ~r_wr;
            end
            if (do_rd) begin
                r_rd <= ~r_rd;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/naive_exact_pattern_matcher_top.sv =====
// ----------------------------------------------------------------------------
// naive_exact_pattern_matcher_top
// Exact pattern search over a text stream; reports match start indices and
// a done result on the final text symbol.
//
//   channel   handshake        payload
//   input     push / full      i_item   (command, symbol, first, last)
//   result    empty / pop      o_result (is_match, match_start, done_res)
//
// A pattern symbol is stored in the pattern memory. When the window holds at
// least m symbols (m = pattern length), a text symbol starts a walk over the
// pattern and window memories, one byte pair per cycle; a match or the final
// text symbol then posts a result. Two-entry queues on both sides let input
// and output stall independently. Reset is synchronous, active low, and
// leaves pattern and text empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module naive_exact_pattern_matcher_top #(
    parameter int MAX_PATTERN   = nepm_pkg::C_MAX_PATTERN,
    parameter int POSITION_BITS = nepm_pkg::C_POSITION_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  nepm_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output nepm_pkg::t_out_item o_result
);
    import nepm_pkg::*;

    logic      cmd_vld;
    t_cmd      cmd;
    logic      cmd_pop;
    logic      res_vld;
    t_out_item res;
    logic      res_full;

    nepm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd),
        .i_cmd_pop (cmd_pop)
    );

    nepm_back #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_full (res_full)
    );

    nepm_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (res_vld),
        .i_res    (res),
        .o_full   (res_full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/nepm_checker.sv =====
// ----------------------------------------------------------------------------
// nepm_checker
// Port-level checks on the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "naive_exact_pattern_matcher_top_defines.svh"

module nepm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_full,
    input logic                i_empty,
    input logic                i_pop,
    input nepm_pkg::t_out_item i_result
);
    import nepm_pkg::*;

    // both queues come out of reset empty
    `NEPM_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> (i_empty && !i_full))
    // a posted result always carries a match or the done mark
    `NEPM_ASSERT(a_res_useful, i_clk, i_rst_n, !i_empty |-> (i_result.is_match || i_result.done_res))
    // no start index without a match
    `NEPM_ASSERT(a_start_zero, i_clk, i_rst_n, (!i_empty && !i_result.is_match) |-> (i_result.match_start == 32'd0))
    // hold a stalled result
    `NEPM_ASSERT(a_res_hold, i_clk, i_rst_n, (!i_empty && !i_pop) |=> (!i_empty && $stable(i_result)))

endmodule

bind naive_exact_pattern_matcher_top nepm_checker u_nepm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_full   (full),
    .i_empty  (empty),
    .i_pop    (pop),
    .i_result (o_result)
);

`default_nettype wire
